FILE: rtl/bp_pkg.sv
// ----------------------------------------------------------------------------
// bp_pkg
// Shared types and constants for the binomial probability unit: request and
// result payloads, the arithmetic unit command set and accumulator view.
// ----------------------------------------------------------------------------
package bp_pkg;

    // Field widths
    localparam int OPC_W     = 1;
    localparam int CNT_W     = 8;                  // n and k
    localparam int NP_W      = CNT_W + 1;          // n + k - 1 for negative binomial
    localparam int FRAC_BITS = 16;                 // probability fraction bits
    localparam int PROB_W    = FRAC_BITS + 1;      // probability incl. exact one
    localparam int RES_W     = 32;                 // Q0.32 result

    // Accumulator: mantissa in [2^31, 2^32) or zero, value = m * 2^-s
    localparam int ACC_M_W   = 32;
    localparam int ACC_EXP_W = 16;                 // covers the exponent swing for n up to 509
    localparam int WIDE_W    = 2 * ACC_M_W;        // product / quotient word
    localparam int PROD_W    = ACC_M_W + PROB_W;
    localparam int NORM_T_W  = 6;                  // total right shift, at most 63

    // Divider: radix-256, eight quotient bits per cycle
    localparam int DIV_BITS_PER_CYCLE = 8;
    localparam int DIV_CYCLES         = WIDE_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

    localparam logic [PROB_W-1:0]  PROB_ONE  = PROB_W'(1) << FRAC_BITS;
    localparam logic [ACC_M_W-1:0] ACC_ONE_M = ACC_M_W'(1) << (ACC_M_W - 1);
    localparam int                 ACC_ONE_S = ACC_M_W - 1;

    localparam logic OPC_BINOM    = 1'b0;
    localparam logic OPC_NEGBINOM = 1'b1;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [CNT_W-1:0]  trials;
        logic [CNT_W-1:0]  successes;
        logic [PROB_W-1:0] prob;
    } bp_in_t;

    typedef struct packed {
        logic [RES_W-1:0] probability;
        logic             error;
    } bp_out_t;

    // Arithmetic unit operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD_ONE,
        OP_MUL_FRAC,
        OP_MUL_INT,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_NORM_HI,
        OP_NORM_LO
    } bp_op_t;

    typedef struct packed {
        bp_op_t            op;
        logic [PROB_W-1:0] operand;   // fraction, integer factor or divisor
    } bp_cmd_t;

    typedef struct packed {
        logic [ACC_M_W-1:0]          m;
        logic signed [ACC_EXP_W-1:0] s;
    } bp_acc_t;

endpackage

FILE: rtl/binomial_probability.sv
// Binomial / negative binomial probability, one request at a time.
// Each multiply (fraction or integer) passes through the shared multiplier and
// normalizer, and each of the k loop passes ends in a divide: the radix-256
// divider steps followed by normalization. Error requests skip the product and
// go straight to the result.
// Synchronous active-low reset returns the sequencer to idle with no result held.
// ----------------------------------------------------------------------------
// binomial_probability
// Top level: request/result handshake, argument checks and the sequencer
// that drives the shared arithmetic unit through the iterative product.
// ----------------------------------------------------------------------------
module binomial_probability (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bp_pkg::bp_in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output bp_pkg::bp_out_t  m_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEQ,
        ST_DIV,
        ST_NORM_HI,
        ST_NORM_LO,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        STEP_INT,
        STEP_FRAC,
        STEP_DIV
    } step_t;

    state_t                          state_reg, state_next;
    step_t                           step_reg, step_next;
    logic [bp_pkg::NP_W-1:0]         np_reg, np_next;
    logic [bp_pkg::NP_W-1:0]         ca_reg, ca_next;
    logic [bp_pkg::NP_W-1:0]         cb_reg, cb_next;
    logic [bp_pkg::CNT_W-1:0]        li_reg, li_next;
    logic                            fin_reg, fin_next;
    logic [bp_pkg::PROB_W-1:0]       fa_reg, fa_next;
    logic [bp_pkg::PROB_W-1:0]       fb_reg, fb_next;
    logic [bp_pkg::PROB_W-1:0]       pp_reg, pp_next;
    logic [bp_pkg::PROB_W-1:0]       pf_reg, pf_next;
    logic [bp_pkg::DIV_CNT_W-1:0]    dcnt_reg, dcnt_next;
    logic                            err_reg, err_next;
    logic                            m_valid_reg, m_valid_next;
    bp_pkg::bp_out_t                 m_data_reg, m_data_next;

    bp_pkg::bp_cmd_t                 cmd;
    bp_pkg::bp_acc_t                 acc;

    logic [bp_pkg::PROB_W-1:0]       p_sat, p_comp, pp_in, qq_in;
    logic [bp_pkg::NP_W-1:0]         np_in, nk_in, k_ext;
    logic                            err_in, direct_in;
    logic [bp_pkg::RES_W-1:0]        q032;

    bp_arith u_arith (
        .aclk (aclk),
        .cmd  (cmd),
        .acc  (acc)
    );

    // Argument decode for a new request
    always_comb begin
        p_sat  = (s_data.prob > bp_pkg::PROB_ONE) ? bp_pkg::PROB_ONE : s_data.prob;
        p_comp = bp_pkg::PROB_ONE - p_sat;
        k_ext  = bp_pkg::NP_W'(s_data.successes);
        if (s_data.opcode == bp_pkg::OPC_NEGBINOM) begin
            np_in  = bp_pkg::NP_W'(s_data.trials) + k_ext - bp_pkg::NP_W'(1);
            pp_in  = p_comp;
            qq_in  = p_sat;
            err_in = (s_data.trials == '0);
        end else begin
            np_in  = bp_pkg::NP_W'(s_data.trials);
            pp_in  = p_sat;
            qq_in  = p_comp;
            err_in = (s_data.successes > s_data.trials);
        end
        nk_in     = np_in - k_ext;
        direct_in = (s_data.successes == '0) || (k_ext == np_in);
    end

    // Accumulator to Q0.32 with saturation and underflow to zero
    always_comb begin
        if (acc.m == '0) begin
            q032 = '0;
        end else if (acc.s <= bp_pkg::ACC_EXP_W'(31)) begin
            q032 = '1;
        end else if (acc.s >= bp_pkg::ACC_EXP_W'(64)) begin
            q032 = '0;
        end else begin
            q032 = acc.m >> 5'(acc.s - bp_pkg::ACC_EXP_W'(32));
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        np_next      = np_reg;
        ca_next      = ca_reg;
        cb_next      = cb_reg;
        li_next      = li_reg;
        fin_next     = fin_reg;
        fa_next      = fa_reg;
        fb_next      = fb_reg;
        pp_next      = pp_reg;
        pf_next      = pf_reg;
        dcnt_next    = dcnt_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        cmd.op       = bp_pkg::OP_NONE;
        cmd.operand  = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op    = bp_pkg::OP_LOAD_ONE;
                    np_next   = np_in;
                    pp_next   = pp_in;
                    pf_next   = p_sat;
                    fin_next  = (s_data.opcode == bp_pkg::OPC_NEGBINOM);
                    step_next = STEP_INT;
                    err_next  = err_in;
                    if (direct_in) begin
                        // p^k (1-p)^(n-k) straight
                        fa_next = pp_in;
                        ca_next = k_ext;
                        fb_next = qq_in;
                        cb_next = nk_in;
                        li_next = '0;
                    end else begin
                        fa_next = qq_in;
                        ca_next = nk_in;
                        fb_next = qq_in;
                        cb_next = '0;
                        li_next = s_data.successes;
                    end
                    state_next = err_in ? ST_DONE : ST_SEQ;
                end
            end
            ST_SEQ: begin
                if (ca_reg != '0) begin
                    cmd.op      = bp_pkg::OP_MUL_FRAC;
                    cmd.operand = fa_reg;
                    ca_next     = ca_reg - bp_pkg::NP_W'(1);
                    state_next  = ST_NORM_HI;
                end else if (cb_reg != '0) begin
                    cmd.op      = bp_pkg::OP_MUL_FRAC;
                    cmd.operand = fb_reg;
                    cb_next     = cb_reg - bp_pkg::NP_W'(1);
                    state_next  = ST_NORM_HI;
                end else if (li_reg != '0) begin
                    // one loop pass: times (n-i+1), times p, divide by i
                    case (step_reg)
                        STEP_INT: begin
                            cmd.op      = bp_pkg::OP_MUL_INT;
                            cmd.operand = bp_pkg::PROB_W'(np_reg - bp_pkg::NP_W'(li_reg)
                                          + bp_pkg::NP_W'(1));
                            step_next   = STEP_FRAC;
                            state_next  = ST_NORM_HI;
                        end
                        STEP_FRAC: begin
                            cmd.op      = bp_pkg::OP_MUL_FRAC;
                            cmd.operand = pp_reg;
                            step_next   = STEP_DIV;
                            state_next  = ST_NORM_HI;
                        end
                        default: begin
                            cmd.op     = bp_pkg::OP_DIV_LOAD;
                            dcnt_next  = '0;
                            state_next = ST_DIV;
                        end
                    endcase
                end else if (fin_reg) begin
                    // negative binomial: final factor p
                    cmd.op      = bp_pkg::OP_MUL_FRAC;
                    cmd.operand = pf_reg;
                    fin_next    = 1'b0;
                    state_next  = ST_NORM_HI;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                cmd.op      = bp_pkg::OP_DIV_STEP;
                cmd.operand = bp_pkg::PROB_W'(li_reg);
                dcnt_next   = dcnt_reg + bp_pkg::DIV_CNT_W'(1);
                if (dcnt_reg == bp_pkg::DIV_CNT_W'(bp_pkg::DIV_CYCLES - 1)) begin
                    li_next    = li_reg - bp_pkg::CNT_W'(1);
                    step_next  = STEP_INT;
                    state_next = ST_NORM_HI;
                end
            end
            ST_NORM_HI: begin
                cmd.op     = bp_pkg::OP_NORM_HI;
                state_next = ST_NORM_LO;
            end
            ST_NORM_LO: begin
                cmd.op     = bp_pkg::OP_NORM_LO;
                state_next = ST_SEQ;
            end
            ST_DONE: begin
                // wait for the result register to free up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (err_reg) begin
                        m_data_next.probability = '0;
                        m_data_next.error       = 1'b1;
                    end else begin
                        m_data_next.probability = q032;
                        m_data_next.error       = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        step_reg   <= step_next;
        np_reg     <= np_next;
        ca_reg     <= ca_next;
        cb_reg     <= cb_next;
        li_reg     <= li_next;
        fin_reg    <= fin_next;
        fa_reg     <= fa_next;
        fb_reg     <= fb_next;
        pp_reg     <= pp_next;
        pf_reg     <= pf_next;
        dcnt_reg   <= dcnt_next;
        err_reg    <= err_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/bp_arith.sv
// ----------------------------------------------------------------------------
// bp_arith
// Shared arithmetic unit: one 32x17 multiplier, a radix-256 divider step and
// a normalizer in a coarse and a fine half, all working on one floating accumulator.
// ----------------------------------------------------------------------------
module bp_arith (
    input  logic             aclk,
    input  bp_pkg::bp_cmd_t  cmd,
    output bp_pkg::bp_acc_t  acc
);

    logic [bp_pkg::ACC_M_W-1:0]          m_reg;
    logic signed [bp_pkg::ACC_EXP_W-1:0] s_reg;
    logic [bp_pkg::WIDE_W-1:0]           w_reg;
    logic [bp_pkg::CNT_W-1:0]            rem_reg;

    logic [bp_pkg::PROD_W-1:0]   prod;
    logic [bp_pkg::WIDE_W-1:0]   div_w;
    logic [bp_pkg::CNT_W-1:0]    div_rem;
    logic [bp_pkg::WIDE_W-1:0]   hi_w;
    logic [bp_pkg::NORM_T_W-1:0] hi_t;
    logic [bp_pkg::WIDE_W-1:0]   lo_w;
    logic [bp_pkg::NORM_T_W-1:0] lo_t;

    // Multiplier, mantissa by fraction or integer factor
    assign prod = bp_pkg::PROD_W'(m_reg) * bp_pkg::PROD_W'(cmd.operand);

    // Eight restoring division steps; remainder stays below the 8-bit divisor
    always_comb begin
        logic [bp_pkg::CNT_W:0]     trial;
        logic [bp_pkg::CNT_W-1:0]   dvs;
        logic [bp_pkg::WIDE_W-1:0]  ww;
        logic [bp_pkg::CNT_W-1:0]   rr;
        dvs = cmd.operand[bp_pkg::CNT_W-1:0];
        ww  = w_reg;
        rr  = rem_reg;
        for (int j = 0; j < bp_pkg::DIV_BITS_PER_CYCLE; j++) begin
            trial = {rr, ww[bp_pkg::WIDE_W-1]};
            ww    = {ww[bp_pkg::WIDE_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs}) begin
                rr    = bp_pkg::CNT_W'(trial - {1'b0, dvs});
                ww[0] = 1'b1;
            end else begin
                rr = trial[bp_pkg::CNT_W-1:0];
            end
        end
        div_w   = ww;
        div_rem = rr;
    end

    // Normalizer, coarse half: right shifts of 32, 16 and 8
    always_comb begin
        int sh;
        hi_w = w_reg;
        hi_t = '0;
        for (int j = 0; j < 3; j++) begin
            sh = 32 >> j;
            if ((hi_w >> (bp_pkg::ACC_M_W - 1 + sh)) != '0) begin
                hi_w = hi_w >> sh;
                hi_t = hi_t + bp_pkg::NORM_T_W'(sh);
            end
        end
    end

    // Normalizer, fine half: right shifts of 4, 2 and 1
    always_comb begin
        int sh;
        lo_w = w_reg;
        lo_t = '0;
        for (int j = 0; j < 3; j++) begin
            sh = 4 >> j;
            if ((lo_w >> (bp_pkg::ACC_M_W - 1 + sh)) != '0) begin
                lo_w = lo_w >> sh;
                lo_t = lo_t + bp_pkg::NORM_T_W'(sh);
            end
        end
    end

    // Accumulator and working registers
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            bp_pkg::OP_LOAD_ONE: begin
                m_reg <= bp_pkg::ACC_ONE_M;
                s_reg <= bp_pkg::ACC_EXP_W'(bp_pkg::ACC_ONE_S);
            end
            bp_pkg::OP_MUL_FRAC: begin
                w_reg <= bp_pkg::WIDE_W'(prod);
                s_reg <= s_reg + bp_pkg::ACC_EXP_W'(bp_pkg::FRAC_BITS);
            end
            bp_pkg::OP_MUL_INT: begin
                w_reg <= bp_pkg::WIDE_W'(prod);
            end
            bp_pkg::OP_DIV_LOAD: begin
                w_reg   <= {m_reg, bp_pkg::ACC_M_W'(0)};
                rem_reg <= '0;
                s_reg   <= s_reg + bp_pkg::ACC_EXP_W'(bp_pkg::ACC_M_W);
            end
            bp_pkg::OP_DIV_STEP: begin
                w_reg   <= div_w;
                rem_reg <= div_rem;
            end
            bp_pkg::OP_NORM_HI: begin
                w_reg <= hi_w;
                s_reg <= s_reg - bp_pkg::ACC_EXP_W'(hi_t);
            end
            bp_pkg::OP_NORM_LO: begin
                m_reg <= lo_w[bp_pkg::ACC_M_W-1:0];
                // zero mantissa carries a zero exponent
                s_reg <= lo_w[bp_pkg::ACC_M_W-1] ? s_reg - bp_pkg::ACC_EXP_W'(lo_t) : '0;
            end
            default: begin
            end
        endcase
    end

    assign acc.m = m_reg;
    assign acc.s = s_reg;

endmodule

FILE: rtl/bp_chk.sv
// ----------------------------------------------------------------------------
// bp_chk
// Port-level checks for the binomial probability unit, bound to the top.
// ----------------------------------------------------------------------------
module bp_chk (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input bp_pkg::bp_in_t   s_data,
    input logic             m_valid,
    input logic             m_ready,
    input bp_pkg::bp_out_t  m_data
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Error results carry zero probability
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error |-> m_data.probability == '0)
        else $error("error result with nonzero probability");

    // One request at a time: busy right after a request is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // A new result only comes out of a busy cycle
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result without work");

endmodule

bind binomial_probability bp_chk u_bp_chk (.*);

FILE: sim/bp_pmf_checker.sv
// ----------------------------------------------------------------------------
// bp_pmf_checker
// Watches both channels of the binomial probability unit. Each accepted
// request gets its expected result from a bit-true model of the iterative
// product. Each accepted result is compared with the oldest of those.
// ----------------------------------------------------------------------------
module bp_pmf_checker
    import bp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_ready,
    input  bp_in_t  s_data,
    input  logic    m_valid,
    input  logic    m_ready,
    input  bp_out_t m_data,
    output int      fail_count,
    output int      outstanding,
    output int      results_checked,
    output int      invalid_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COUNT   = 255;
    localparam int FLUSH_LIMIT = 1000000;

    // Wide accumulator: value = mant * 2^-expo, mant zero or in [2^31, 2^32)
    typedef struct {
        bit [63:0] mant;
        int        expo;
    } wide_acc_t;

    bp_out_t expected_pmf_q[$];
    int      mismatches    = 0;
    int      pending_cnt   = 0;
    int      checked_cnt   = 0;
    int      invalid_cnt   = 0;

    assign fail_count      = mismatches;
    assign outstanding     = pending_cnt;
    assign results_checked = checked_cnt;
    assign invalid_results = invalid_cnt;

    // Bring the mantissa back into [2^31, 2^32), truncating on the right
    function automatic wide_acc_t renorm(wide_acc_t a);
        if (a.mant == 64'd0) begin
            a.expo = 0;
            return a;
        end
        while (a.mant > 64'hFFFF_FFFF) begin
            a.mant = a.mant >> 1;
            a.expo--;
        end
        while (a.mant < 64'h8000_0000) begin
            a.mant = a.mant << 1;
            a.expo++;
        end
        if (a.expo > FLUSH_LIMIT) begin
            a.mant = '0;
            a.expo = 0;
        end
        return a;
    endfunction

    function automatic wide_acc_t scale_by_frac(wide_acc_t a, bit [63:0] f);
        a.mant = a.mant * f;
        a.expo += FRAC_BITS;
        return renorm(a);
    endfunction

    function automatic wide_acc_t scale_by_int(wide_acc_t a, bit [63:0] v);
        a.mant = a.mant * v;
        return renorm(a);
    endfunction

    function automatic wide_acc_t divide_by(wide_acc_t a, bit [63:0] d);
        if (d == 64'd0)
            d = 64'd1;
        a.mant = (a.mant << 32) / d;
        a.expo += 32;
        return renorm(a);
    endfunction

    // C(n,k) p^k (1-p)^(n-k); the edge counts use plain powers
    function automatic wide_acc_t pmf_product(int n, int k, bit [63:0] p);
        bit [63:0] q;
        wide_acc_t a;
        q      = 64'(PROB_ONE) - p;
        a.mant = 64'h8000_0000;
        a.expo = 31;
        if (k == 0 || k == n) begin
            for (int i = 0; i < k; i++)
                a = scale_by_frac(a, p);
            for (int i = 0; i < n - k; i++)
                a = scale_by_frac(a, q);
            return a;
        end
        for (int i = 0; i < n - k; i++)
            a = scale_by_frac(a, q);
        for (int i = k; i > 0; i--) begin
            a = scale_by_int(a, 64'(n - i + 1));
            a = scale_by_frac(a, p);
            a = divide_by(a, 64'(i));
        end
        return a;
    endfunction

    // Truncate to Q0.32; 1.0 and above saturate
    function automatic bit [31:0] acc_to_q32(wide_acc_t a);
        int sh;
        if (a.mant == 64'd0)
            return 32'd0;
        if (a.expo <= 31)
            return 32'hFFFF_FFFF;
        sh = a.expo - 32;
        if (sh >= 32)
            return 32'd0;
        return 32'(a.mant >> sh);
    endfunction

    function automatic bp_out_t predict_pmf(bp_in_t req);
        bp_out_t   res;
        bit [63:0] p;
        bit [63:0] one;
        int        n;
        int        k;
        bit        bad;
        wide_acc_t a;
        one = 64'(PROB_ONE);
        p   = 64'(req.prob);
        if (p > one)
            p = one;
        n   = int'(req.trials);
        k   = int'(req.successes);
        bad = (n > MAX_COUNT) || (k > MAX_COUNT);
        if (req.opcode == OPC_BINOM)
            bad = bad || (k > n);
        else
            bad = bad || (n == 0);
        res.probability = '0;
        res.error       = bad;
        if (bad)
            return res;
        if (req.opcode == OPC_BINOM) begin
            a = pmf_product(n, k, p);
        end else begin
            a = pmf_product(n + k - 1, k, one - p);
            a = scale_by_frac(a, p);
        end
        res.probability = acc_to_q32(a);
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: result mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Queue a prediction per request, check each result against the oldest
    always @(posedge aclk) begin
        bp_out_t want;
        string   msg;
        if (!aresetn) begin
            expected_pmf_q.delete();
        end else begin
            if (s_valid && s_ready)
                expected_pmf_q.push_back(predict_pmf(s_data));
            if (m_valid && m_ready) begin
                if (expected_pmf_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result prob=%h err=%0b",
                                              m_data.probability, m_data.error));
                end else begin
                    want = expected_pmf_q.pop_front();
                    msg  = "";
                    if (m_data.probability !== want.probability)
                        msg = {msg, $sformatf(" probability got %h want %h",
                                              m_data.probability, want.probability)};
                    if (m_data.error !== want.error)
                        msg = {msg, $sformatf(" error got %b want %b",
                                              m_data.error, want.error)};
                    if (msg != "")
                        report_mismatch({"result", msg});
                    checked_cnt++;
                    if (m_data.error === 1'b1)
                        invalid_cnt++;
                end
            end
        end
        pending_cnt <= expected_pmf_q.size();
    end

endmodule

FILE: sim/tb_binomial_probability.sv
// ----------------------------------------------------------------------------
// tb_binomial_probability
// Drives requests into the binomial probability unit: a directed set of edge
// cases, then random requests under four handshake pressure phases. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_binomial_probability;
    import bp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_PER_PHASE = 68;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int TAIL_CYCLES    = 32;

    logic    aclk = 1'b0;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    bp_in_t  s_data;
    logic    m_valid;
    logic    m_ready;
    bp_out_t m_data;

    int fail_count;
    int outstanding;
    int results_checked;
    int invalid_results;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;
    int binom_sent     = 0;
    int negbinom_sent  = 0;

    binomial_probability u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    bp_pmf_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .invalid_results (invalid_results)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: too long without any accepted request or result
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("[binomial_probability] ERROR");
            $finish;
        end
    end

    function automatic bp_in_t pack_request(bit op, int n, int k, int p);
        bp_in_t r;
        r.opcode    = op;
        r.trials    = CNT_W'(n);
        r.successes = CNT_W'(k);
        r.prob      = PROB_W'(p);
        return r;
    endfunction

    // Mostly small valid sizes, some large ones, some invalid arguments
    function automatic bp_in_t random_request();
        int kind;
        int n;
        int k;
        int p;
        bit op;
        kind = $urandom_range(99);
        op   = $urandom_range(1);
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: p = 0;
                    1: p = 1;
                    2: p = 65535;
                    default: p = 65536;
                endcase
            end
            1: p = $urandom_range(131071);
            default: p = $urandom_range(65536);
        endcase
        if (kind < 8) begin
            // invalid: k above n, or no trials for negative binomial
            if (op == OPC_BINOM) begin
                n = $urandom_range(254);
                k = $urandom_range(255, n + 1);
            end else begin
                n = 0;
                k = $urandom_range(255);
            end
        end else if (kind < 14) begin
            if (op == OPC_BINOM) begin
                n = $urandom_range(255, 128);
                k = $urandom_range(n);
            end else begin
                n = $urandom_range(255, 1);
                k = $urandom_range(255);
            end
        end else begin
            if (op == OPC_BINOM) begin
                n = $urandom_range(40);
                case ($urandom_range(9))
                    0: k = 0;
                    1: k = n;
                    default: k = $urandom_range(n);
                endcase
            end else begin
                n = $urandom_range(40, 1);
                k = $urandom_range(40);
            end
        end
        return pack_request(op, n, k, p);
    endfunction

    // Present one request and hold it until accepted
    task automatic send_request(bp_in_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        if (req.opcode == OPC_BINOM)
            binom_sent++;
        else
            negbinom_sent++;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_data         <= '0;
        recv_stall_pct <= 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: edges of every field, both operations, special cases
        send_request(pack_request(OPC_BINOM, 0, 0, 12345));         // empty product, one
        send_request(pack_request(OPC_BINOM, 3, 5, 30000));         // k above n
        send_request(pack_request(OPC_BINOM, 0, 255, 65535));       // k above n, all ones k
        send_request(pack_request(OPC_BINOM, 255, 255, 65536));     // p exactly one
        send_request(pack_request(OPC_BINOM, 255, 0, 0));           // q exactly one
        send_request(pack_request(OPC_BINOM, 255, 128, 32768));     // iterative run, k near n/2
        send_request(pack_request(OPC_BINOM, 10, 3, 0));            // p zero
        send_request(pack_request(OPC_BINOM, 10, 3, 65536));        // q zero
        send_request(pack_request(OPC_BINOM, 5, 2, 131071));        // p above one, clamped
        send_request(pack_request(OPC_BINOM, 5, 5, 65537));         // clamped to one
        send_request(pack_request(OPC_BINOM, 255, 1, 1));           // smallest nonzero p
        send_request(pack_request(OPC_BINOM, 1, 1, 65535));
        send_request(pack_request(OPC_BINOM, 2, 1, 32768));         // exactly one half
        send_request(pack_request(OPC_NEGBINOM, 0, 7, 40000));      // no trials
        send_request(pack_request(OPC_NEGBINOM, 0, 0, 0));          // no trials, zero k
        send_request(pack_request(OPC_NEGBINOM, 1, 0, 65536));      // result of one
        send_request(pack_request(OPC_NEGBINOM, 255, 255, 32768));  // widest n + k - 1
        send_request(pack_request(OPC_NEGBINOM, 1, 255, 1));
        send_request(pack_request(OPC_NEGBINOM, 20, 5, 20000));
        send_request(pack_request(OPC_NEGBINOM, 128, 0, 131071));   // p above one
        send_request(pack_request(OPC_NEGBINOM, 3, 2, 0));          // p zero

        // Random requests under each pressure phase
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct   = 51;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 51;
                end
                default: begin
                    send_idle_pct   = 38;
                    recv_stall_pct <= 38;
                end
            endcase
            for (int i = 0; i < RAND_PER_PHASE; i++)
                send_request(random_request());
        end
        s_valid <= 1'b0;

        // Drain, then watch a little longer for stray results
        do
            @(posedge aclk);
        while (outstanding != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d requests (%0d binomial, %0d negative binomial)",
                 binom_sent + negbinom_sent, binom_sent, negbinom_sent);
        $display("across four pressure phases: %0d results checked, %0d invalid, %0d bad",
                 results_checked, invalid_results, fail_count);
        if (fail_count == 0)
            $display("[binomial_probability] OK");
        else
            $display("[binomial_probability] ERROR");
        $finish;
    end

endmodule

FILE: binomial_probability.f
rtl/bp_pkg.sv
rtl/bp_arith.sv
rtl/binomial_probability.sv
rtl/bp_chk.sv
sim/bp_pmf_checker.sv
sim/tb_binomial_probability.sv
